FILE: design/bee_pkg.sv
// ----------------------------------------------------------------------------
// bee_pkg
// Token codes, sequencer states, stack command group and the operator
// precedence and evaluation functions of the boolean expression evaluator.
// ----------------------------------------------------------------------------
package bee_pkg;

    localparam int OPC_W = 4;

    localparam logic [OPC_W-1:0] OPC_OPERAND = 4'd0;
    localparam logic [OPC_W-1:0] OPC_OPEN    = 4'd1;
    localparam logic [OPC_W-1:0] OPC_CLOSE   = 4'd2;
    localparam logic [OPC_W-1:0] OPC_IMPL    = 4'd3;
    localparam logic [OPC_W-1:0] OPC_NOR     = 4'd4;
    localparam logic [OPC_W-1:0] OPC_OR      = 4'd5;
    localparam logic [OPC_W-1:0] OPC_XNOR    = 4'd6;
    localparam logic [OPC_W-1:0] OPC_XOR     = 4'd7;
    localparam logic [OPC_W-1:0] OPC_NAND    = 4'd8;
    localparam logic [OPC_W-1:0] OPC_AND     = 4'd9;
    localparam logic [OPC_W-1:0] OPC_NOT     = 4'd10;
    localparam logic [OPC_W-1:0] OPC_END     = 4'd11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLOSE,
        S_BINOP,
        S_END
    } t_state;

    // One command to a stack per cycle; pop together with set_top replaces
    // the two top entries by one.
    typedef struct packed {
        logic push;
        logic pop;
        logic set_top;
        logic clear;
    } t_stk_cmd;

    // Precedence offset by two so that parentheses (lowest) sit at zero.
    function automatic logic [2:0] f_prec(input logic [OPC_W-1:0] op);
        logic [2:0] p;
        case (op)
            OPC_OPEN, OPC_CLOSE: p = 3'd0;
            OPC_IMPL:            p = 3'd3;
            OPC_NOR, OPC_OR:     p = 3'd4;
            OPC_XNOR, OPC_XOR:   p = 3'd5;
            OPC_NAND, OPC_AND:   p = 3'd6;
            OPC_NOT:             p = 3'd7;
            default:             p = 3'd2;
        endcase
        return p;
    endfunction

    function automatic logic f_apply(input logic a, input logic [OPC_W-1:0] op,
                                     input logic b);
        logic r;
        case (op)
            OPC_IMPL: r = ~a | b;
            OPC_NOR:  r = ~(a | b);
            OPC_OR:   r = a | b;
            OPC_XNOR: r = ~(a ^ b);
            OPC_XOR:  r = a ^ b;
            OPC_NAND: r = ~(a & b);
            OPC_AND:  r = a & b;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/bee_stack.sv
// ----------------------------------------------------------------------------
// bee_stack
// Stack with the top entry in a register and the rest in a synchronous
// memory; the read port always holds the entry below the top.
// ----------------------------------------------------------------------------
module bee_stack #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bee_pkg::t_stk_cmd            i_cmd,
    input  logic [WIDTH-1:0]             i_data,
    output logic [WIDTH-1:0]             o_top,
    output logic [WIDTH-1:0]             o_second,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import bee_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_top, n_top;
    logic [WIDTH-1:0] r_second;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    w_cnt_m1;
    logic [CW-1:0]    w_ncnt_m2;
    logic             w_can_push;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;

    assign w_can_push = (r_count < CW'(DEPTH));
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_ncnt_m2  = n_count - CW'(2);
    // spill the old top below the new one
    assign w_we       = i_cmd.push && w_can_push && (r_count != '0);
    assign w_waddr    = w_cnt_m1[AW-1:0];
    assign w_raddr    = (n_count >= CW'(2)) ? w_ncnt_m2[AW-1:0] : '0;

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            if (w_can_push) begin
                n_count = r_count + CW'(1);
                n_top   = i_data;
            end
        end else if (i_cmd.pop) begin
            if (r_count != '0) begin
                n_count = w_cnt_m1;
            end
            n_top = i_cmd.set_top ? i_data : r_second;
        end else if (i_cmd.set_top) begin
            n_top = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    // memory with write-first forwarding on the entry below the top
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_top;
        end
        if (w_we && (w_waddr == w_raddr)) begin
            r_second <= r_top;
        end else begin
            r_second <= r_mem[w_raddr];
        end
    end

    assign o_top    = r_top;
    assign o_second = r_second;
    assign o_count  = r_count;

endmodule

FILE: design/boolean_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// boolean_expression_evaluator_top
// Infix boolean expression evaluator with operator and value stacks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one token per item:
//   i_opcode and i_operand_value. Output channel (o_out_valid / i_out_ready)
//   carries one item per end token: o_result_value and o_error_flag.
//   Operand, open paren, not, a binary operator taken as not and unused codes
//   are taken in the idle state, which the block does not leave for them.
//   Binary operator and close paren: the block leaves the idle state and
//   reduces the stacked operators, one reduction per cycle, set by the
//   operator stack top register and the read port that holds the entry
//   below it; then it pushes the operator or pops the matching open paren.
//   End token: after its reductions, once the output register is free, its
//   result and o_out_valid are registered, and both stacks, the error flag
//   and the operand tracking are cleared.
//   Reset (synchronous, active low) empties both stacks and the output
//   register. While a result waits, tokens are still taken; only a further
//   end token holds in its final step until the output register is free.
// ----------------------------------------------------------------------------
module boolean_expression_evaluator_top #(
    parameter int OP_STACK_DEPTH    = 16,
    parameter int VALUE_STACK_DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [bee_pkg::OPC_W-1:0] i_opcode,
    input  logic                      i_operand_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_result_value,
    output logic                      o_error_flag
);
    import bee_pkg::*;

    localparam int OCW = $clog2(OP_STACK_DEPTH + 1);
    localparam int VCW = $clog2(VALUE_STACK_DEPTH + 1);

    t_state           r_state, n_state;
    logic [OPC_W-1:0] r_op, n_op;
    logic             r_lwo, n_lwo;
    logic             r_sticky, n_sticky;
    logic             r_out_valid, n_out_valid;
    logic             r_result, n_result;
    logic             r_err_out, n_err_out;

    t_stk_cmd         w_ocmd, w_vcmd;
    logic [OPC_W-1:0] w_odata;
    logic             w_vdata;
    logic [OPC_W-1:0] w_otop, w_osec;
    logic             w_vtop, w_vsec;
    logic [OCW-1:0]   w_ocnt;
    logic [VCW-1:0]   w_vcnt;

    t_stk_cmd         w_red_vcmd;
    logic             w_red_vdata;
    logic             w_red_err;
    logic             w_accept;
    logic             w_out_free;
    logic             w_ofull;
    logic             w_vfull;
    logic [OPC_W-1:0] w_binop;

    bee_stack #(.WIDTH(OPC_W), .DEPTH(OP_STACK_DEPTH)) u_op_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_ocmd),
        .i_data   (w_odata),
        .o_top    (w_otop),
        .o_second (w_osec),
        .o_count  (w_ocnt)
    );

    bee_stack #(.WIDTH(1), .DEPTH(VALUE_STACK_DEPTH)) u_val_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_vcmd),
        .i_data   (w_vdata),
        .o_top    (w_vtop),
        .o_second (w_vsec),
        .o_count  (w_vcnt)
    );

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_ofull    = (w_ocnt >= OCW'(OP_STACK_DEPTH));
    assign w_vfull    = (w_vcnt >= VCW'(VALUE_STACK_DEPTH));
    assign w_binop    = (r_lwo || (w_ocnt == '0 && w_vcnt == '0)) ? OPC_NOT : i_opcode;

    // Value-stack effect of popping and applying the top operator.
    always_comb begin
        w_red_vcmd  = '0;
        w_red_vdata = 1'b0;
        w_red_err   = 1'b0;
        case (w_otop)
            OPC_OPEN, OPC_CLOSE: begin
                w_red_err = 1'b1;
            end
            OPC_NOT: begin
                if (w_vcnt == '0) begin
                    w_red_err = 1'b1;
                end else begin
                    w_red_vcmd.set_top = 1'b1;
                    w_red_vdata        = ~w_vtop;
                end
            end
            default: begin
                if (w_vcnt < VCW'(2)) begin
                    w_red_err = 1'b1;
                end else begin
                    w_red_vcmd.pop     = 1'b1;
                    w_red_vcmd.set_top = 1'b1;
                    w_red_vdata        = f_apply(w_vsec, w_otop, w_vtop);
                end
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_lwo       = r_lwo;
        n_sticky    = r_sticky;
        n_out_valid = r_out_valid && !i_out_ready;
        n_result    = r_result;
        n_err_out   = r_err_out;
        w_ocmd      = '0;
        w_vcmd      = '0;
        w_odata     = i_opcode;
        w_vdata     = i_operand_value;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept) begin
                    case (i_opcode) inside
                        OPC_OPERAND: begin
                            if (w_vfull) begin
                                n_sticky = 1'b1;
                            end else begin
                                w_vcmd.push = 1'b1;
                            end
                            n_lwo = 1'b0;
                        end
                        OPC_OPEN: begin
                            if (w_ofull) begin
                                n_sticky = 1'b1;
                            end else begin
                                w_ocmd.push = 1'b1;
                            end
                            n_lwo = 1'b1;
                        end
                        OPC_CLOSE: begin
                            n_lwo   = 1'b0;
                            n_state = S_CLOSE;
                        end
                        [OPC_IMPL:OPC_NOT]: begin
                            n_lwo = 1'b1;
                            if (w_binop == OPC_NOT) begin
                                w_odata = OPC_NOT;
                                if (w_ofull) begin
                                    n_sticky = 1'b1;
                                end else begin
                                    w_ocmd.push = 1'b1;
                                end
                            end else begin
                                n_op    = w_binop;
                                n_state = S_BINOP;
                            end
                        end
                        OPC_END: begin
                            n_state = S_END;
                        end
                        default: begin
                            // unused codes: drop
                        end
                    endcase
                end
            end
            S_CLOSE: begin
                if (w_ocnt != '0 && w_otop != OPC_OPEN) begin
                    w_ocmd.pop = 1'b1;
                    w_vcmd     = w_red_vcmd;
                    w_vdata    = w_red_vdata;
                    n_sticky   = r_sticky | w_red_err;
                end else begin
                    if (w_ocnt != '0) begin
                        w_ocmd.pop = 1'b1;
                    end else begin
                        n_sticky = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_BINOP: begin
                if (w_ocnt != '0 && f_prec(w_otop) >= f_prec(r_op)) begin
                    w_ocmd.pop = 1'b1;
                    w_vcmd     = w_red_vcmd;
                    w_vdata    = w_red_vdata;
                    n_sticky   = r_sticky | w_red_err;
                end else begin
                    w_odata = r_op;
                    if (w_ofull) begin
                        n_sticky = 1'b1;
                    end else begin
                        w_ocmd.push = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_END: begin
                if (w_ocnt != '0) begin
                    w_ocmd.pop = 1'b1;
                    w_vcmd     = w_red_vcmd;
                    w_vdata    = w_red_vdata;
                    n_sticky   = r_sticky | w_red_err;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_result     = (w_vcnt == '0) ? 1'b1 : w_vtop;
                    n_err_out    = r_sticky;
                    w_ocmd.clear = 1'b1;
                    w_vcmd.clear = 1'b1;
                    n_lwo        = 1'b0;
                    n_sticky     = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lwo       <= 1'b0;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lwo       <= n_lwo;
            r_sticky    <= n_sticky;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_result  <= n_result;
        r_err_out <= n_err_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign o_error_flag   = r_err_out;

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ocnt <= OCW'(OP_STACK_DEPTH)) && (w_vcnt <= VCW'(VALUE_STACK_DEPTH)))
        else $error("stack count beyond depth");

    a_binop_is_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BINOP) |->
        (r_op != OPC_NOT && r_op != OPC_OPEN && r_op != OPC_CLOSE))
        else $error("pending operator is not binary");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && w_ocnt == '0 && w_out_free) |=>
        (o_out_valid && w_ocnt == '0 && w_vcnt == '0 && !r_sticky && !r_lwo))
        else $error("end token left state behind");

    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_END))
        else $error("result raised outside end token");

    a_hold_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END && w_ocnt == '0 && r_out_valid && !i_out_ready) |=>
        (r_state == S_END))
        else $error("end token overwrote waiting result");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds token streams into boolean_expression_evaluator_top and checks every
// result item against a stack-based predictor or a typed table value. A short
// table of directed tokens is followed by random expressions, noise, broken
// expressions and stack overflow runs. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    import bee_pkg::*;

    localparam int OPS_DEPTH      = 16;
    localparam int VALS_DEPTH     = 16;
    localparam int TOTAL_ITEMS    = 450;
    localparam int PAUSE_AT       = 300;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int N_DIRECTED     = 26;

    // Highest code the block ignores
    localparam logic [OPC_W-1:0] OPC_SPARE_LAST  = 4'd15;

    typedef struct packed {
        logic [OPC_W-1:0] opc;
        logic             val;
    } t_token;

    typedef struct packed {
        logic value;
        logic error;
    } t_result;

    typedef struct packed {
        t_token  tok;
        logic    typed;
        t_result res;
    } t_step;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    logic             i_clk;
    logic             i_rst_n         = 1'b0;
    logic             in_valid        = 1'b0;
    logic [OPC_W-1:0] opcode          = OPC_OPERAND;
    logic             operand_value   = 1'b0;
    logic             out_ready       = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_result_value;
    logic             o_error_flag;

    // Predictor state
    logic [OPC_W-1:0] pending_ops [OPS_DEPTH];
    logic             operand_vals [VALS_DEPTH];
    int               op_depth     = 0;
    int               val_depth    = 0;
    bit               want_operand = 1'b0;
    bit               stack_fault  = 1'b0;

    t_result          expected_results [$];
    t_token           seq_q [$];
    t_step            directed_steps [N_DIRECTED];

    int               mismatch_count = 0;
    int               items_done     = 0;
    int               burst_left     = 0;
    int               idle_cycles    = 0;
    bit               hold_req       = 1'b0;
    bit               paused         = 1'b0;

    boolean_expression_evaluator_top #(
        .OP_STACK_DEPTH   (OPS_DEPTH),
        .VALUE_STACK_DEPTH(VALS_DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (opcode),
        .i_operand_value(operand_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_result_value (o_result_value),
        .o_error_flag   (o_error_flag)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int rank(input logic [OPC_W-1:0] op);
        case (op)
            OPC_IMPL:          return 1;
            OPC_NOR, OPC_OR:   return 2;
            OPC_XNOR, OPC_XOR: return 3;
            OPC_NAND, OPC_AND: return 4;
            OPC_NOT:           return 5;
            default:           return -1;
        endcase
    endfunction

    function automatic void push_operator(input logic [OPC_W-1:0] op);
        if (op_depth >= OPS_DEPTH) begin
            stack_fault = 1'b1;
        end else begin
            pending_ops[op_depth] = op;
            op_depth++;
        end
    endfunction

    function automatic void apply_top_operator();
        logic [OPC_W-1:0] op;
        logic             a;
        logic             b;
        logic             r;
        op = pending_ops[op_depth-1];
        op_depth--;
        if (op == OPC_OPEN || op == OPC_CLOSE) begin
            stack_fault = 1'b1;
        end else if (op == OPC_NOT) begin
            if (val_depth < 1) begin
                stack_fault = 1'b1;
            end else begin
                operand_vals[val_depth-1] = ~operand_vals[val_depth-1];
            end
        end else if (val_depth < 2) begin
            // leave the value stack as it is
            stack_fault = 1'b1;
        end else begin
            b = operand_vals[val_depth-1];
            a = operand_vals[val_depth-2];
            case (op)
                OPC_IMPL: r = ~a | b;
                OPC_NOR:  r = ~(a | b);
                OPC_OR:   r = a | b;
                OPC_XNOR: r = ~(a ^ b);
                OPC_XOR:  r = a ^ b;
                OPC_NAND: r = ~(a & b);
                OPC_AND:  r = a & b;
                default:  r = 1'b0;
            endcase
            val_depth--;
            operand_vals[val_depth-1] = r;
        end
    endfunction

    // Returns 1 when the token yields a result item
    function automatic bit evaluate_token(input t_token tok, output t_result res);
        logic [OPC_W-1:0] op;
        res = '0;
        if (tok.opc == OPC_OPERAND) begin
            if (val_depth >= VALS_DEPTH) begin
                stack_fault = 1'b1;
            end else begin
                operand_vals[val_depth] = tok.val;
                val_depth++;
            end
            want_operand = 1'b0;
        end else if (tok.opc == OPC_OPEN) begin
            push_operator(OPC_OPEN);
            want_operand = 1'b1;
        end else if (tok.opc == OPC_CLOSE) begin
            while (op_depth > 0 && pending_ops[op_depth-1] != OPC_OPEN)
                apply_top_operator();
            if (op_depth > 0) begin
                op_depth--;
            end else begin
                stack_fault = 1'b1;
            end
            want_operand = 1'b0;
        end else if (tok.opc <= OPC_NOT) begin
            op = tok.opc;
            // operator where an operand belongs: treat as not
            if (want_operand || (op_depth == 0 && val_depth == 0))
                op = OPC_NOT;
            if (op != OPC_NOT) begin
                while (op_depth > 0 && rank(pending_ops[op_depth-1]) >= rank(op))
                    apply_top_operator();
            end
            push_operator(op);
            want_operand = 1'b1;
        end else if (tok.opc == OPC_END) begin
            while (op_depth > 0)
                apply_top_operator();
            res.value    = (val_depth == 0) ? 1'b1 : operand_vals[val_depth-1];
            res.error    = stack_fault;
            op_depth     = 0;
            val_depth    = 0;
            want_operand = 1'b0;
            stack_fault  = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_token(input t_token tok, input bit typed, input t_result typed_res);
        int      gap;
        t_result predicted;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_valid      <= 1'b1;
        opcode        <= tok.opc;
        operand_value <= tok.val;
        do @(posedge i_clk); while (!o_in_ready);
        if (evaluate_token(tok, predicted))
            expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
        if (tok.opc <= OPC_END) begin
            items_done++;
            if (items_done == HOLD_AT)
                hold_req = 1'b1;
        end
        burst_left--;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result is in
    task automatic wait_for_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    function automatic void add_token(input logic [OPC_W-1:0] opc, input logic val);
        t_token t;
        t.opc = opc;
        t.val = val;
        seq_q.insert(seq_q.size(), t);
    endfunction

    task automatic gen_expr(input int lvl);
        int n;
        gen_term(lvl);
        n = $urandom_range(0, 3);
        repeat (n) begin
            add_token(OPC_W'($urandom_range(OPC_IMPL, OPC_AND)), 1'($urandom_range(0, 1)));
            gen_term(lvl);
        end
    endtask

    task automatic gen_term(input int lvl);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            add_token(OPC_NOT, 1'($urandom_range(0, 1)));
            gen_term(lvl);
        end else if (r < 5 && lvl > 0) begin
            add_token(OPC_OPEN, 1'($urandom_range(0, 1)));
            gen_expr(lvl - 1);
            add_token(OPC_CLOSE, 1'($urandom_range(0, 1)));
        end else begin
            add_token(OPC_OPERAND, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic build_sequence();
        int     kind;
        int     n;
        int     idx;
        t_token t;
        seq_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            gen_expr(3);
            add_token(OPC_END, 1'($urandom_range(0, 1)));
        end else if (kind < 80) begin
            // noise, unused codes included
            n = $urandom_range(1, 8);
            repeat (n)
                add_token(OPC_W'($urandom_range(OPC_OPERAND, OPC_SPARE_LAST)),
                          1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                add_token(OPC_END, 1'($urandom_range(0, 1)));
        end else if (kind < 85) begin
            // run the operator stack to near or past its depth
            n = $urandom_range(OPS_DEPTH - 2, OPS_DEPTH + 4);
            repeat (n)
                add_token($urandom_range(0, 1) ? OPC_OPEN : OPC_NOT, 1'($urandom_range(0, 1)));
            add_token(OPC_OPERAND, 1'($urandom_range(0, 1)));
            add_token(OPC_END, 1'($urandom_range(0, 1)));
        end else if (kind < 90) begin
            // run the value stack to near or past its depth
            n = $urandom_range(VALS_DEPTH - 2, VALS_DEPTH + 4);
            repeat (n)
                add_token(OPC_OPERAND, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) begin
                add_token(OPC_W'($urandom_range(OPC_IMPL, OPC_AND)), 1'($urandom_range(0, 1)));
                add_token(OPC_OPERAND, 1'($urandom_range(0, 1)));
            end
            add_token(OPC_END, 1'($urandom_range(0, 1)));
        end else begin
            // broken expression: drop one token or slip in a stray one
            gen_expr(2);
            idx = $urandom_range(0, seq_q.size() - 1);
            if ($urandom_range(0, 1) && seq_q.size() > 1) begin
                seq_q.delete(idx);
            end else begin
                t.opc = OPC_W'($urandom_range(OPC_OPERAND, OPC_NOT));
                t.val = 1'($urandom_range(0, 1));
                seq_q.insert(idx, t);
            end
            add_token(OPC_END, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        directed_steps = '{
            '{'{OPC_END,     1'b0}, 1'b1, '{1'b1, 1'b0}},  // empty expression is true
            '{'{OPC_OPEN,    1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_OPERAND, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_IMPL,    1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_OPERAND, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_CLOSE,   1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_XNOR,    1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_NOT,     1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_OPERAND, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_AND,     1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_OPERAND, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_END,     1'b1}, 1'b0, '{1'b0, 1'b0}},
            // leading binary operator turns into not
            '{'{OPC_NOR,     1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_OPERAND, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_OR,      1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_OPERAND, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_XOR,     1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_OPERAND, 1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_NAND,    1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_OPERAND, 1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_END,     1'b0}, 1'b0, '{1'b0, 1'b0}},
            // unmatched close, then unmatched open
            '{'{OPC_CLOSE,   1'b0}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_END,     1'b0}, 1'b1, '{1'b1, 1'b1}},
            '{'{OPC_OPEN,    1'b1}, 1'b0, '{1'b0, 1'b0}},
            '{'{OPC_END,     1'b1}, 1'b1, '{1'b1, 1'b1}},
            '{'{OPC_SPARE_LAST, 1'b1}, 1'b0, '{1'b0, 1'b0}}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_token(directed_steps[i].tok, directed_steps[i].typed, directed_steps[i].res);
        wait_for_results();

        while (items_done < TOTAL_ITEMS) begin
            if (!paused && items_done >= PAUSE_AT) begin
                paused = 1'b1;
                wait_for_results();
            end
            build_sequence();
            foreach (seq_q[k])
                send_token(seq_q[k], 1'b0, '0);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("boolean_expression_evaluator_top test passed");
        end else begin
            $display("boolean_expression_evaluator_top test failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        t_rx_mode mode;
        int       mode_left;
        mode      = RX_STREAM;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_STREAM: out_ready <= 1'b1;
                    RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
                    default:   out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_failure($sformatf("unexpected result value=%0b error=%0b",
                                         o_result_value, o_error_flag));
            end else begin
                want = expected_results.pop_front();
                if (o_result_value !== want.value)
                    report_failure($sformatf("result_value expected %0b got %0b",
                                             want.value, o_result_value));
                if (o_error_flag !== want.error)
                    report_failure($sformatf("error_flag expected %0b got %0b",
                                             want.error, o_error_flag));
            end
        end
    end

    // Count cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("boolean_expression_evaluator_top test failed");
            $finish;
        end
    end

endmodule
